>>> hw/rtl/admm_pkg.sv
// Package for the two-node ADMM dimming solver: opcodes, operand selects,
// micro-instruction format, the micro-program ROM and controller states.
// No dependencies; every other file of the block but admm_if imports it.
package admm_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned CFG_W = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PC_W = 7;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic signed [WORD_W-1:0] Q_ONE = 32'sd65536;
  localparam logic signed [WORD_W-1:0] TOL_Q = 32'sd66;
  localparam logic signed [WORD_W-1:0] HUNDRED_Q = 32'sd6553600;
  localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_COST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LUX_TARGET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_LUX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_OWN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_OTHER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY_RHO = 3'd5;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_AVG, OP_FEAS, OP_KEEP, OP_INIT,
    OP_CALL, OP_RET, OP_EMIT, OP_DONE
  } op_t;

  // Operand and destination selects: scratch entries first, then named sources.
  typedef enum logic [5:0] {
    T0, T1, T2, T3, T4, T5, T6, T7, T8, T9, T10, T11, T12, T13, T14, T15,
    S_C, S_L, S_O, S_K0, S_K1, S_RHO, S_AO, S_AT, S_MO, S_MT,
    S_ZERO, S_HUND, S_NTOL, S_HTOL, S_TOL, S_RHOH, S_BO, S_BT, S_PS, S_PP
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t dst;
    sel_t a;
    sel_t b;
  } uins_t;

  typedef struct packed {
    logic  load_in;
    logic  fetch;
    logic  start;
    uins_t ins;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_EXEC, ST_WAIT, ST_OUT
  } ctrl_state_t;

  localparam logic [PC_W-1:0] PC_PRIMAL = 7'd0;
  localparam logic [PC_W-1:0] PC_BODY = 7'd50;
  localparam logic [PC_W-1:0] PC_CONS = 7'd72;

  function automatic uins_t mk(input op_t op, input sel_t dst, input sel_t a, input sel_t b);
    uins_t u;
    u.op = op;
    u.dst = dst;
    u.a = a;
    u.b = b;
    return u;
  endfunction

  // Micro-program. The primal step computes shared terms, loads each candidate
  // pair into T8/T9 and calls the shared feasibility and cost body.
  function automatic uins_t rom(input logic [PC_W-1:0] pc);
    uins_t u;
    case (pc)
      7'd0:  u = mk(OP_MUL, T0, S_RHO, S_AO);
      7'd1:  u = mk(OP_SUB, T1, T0, S_C);
      7'd2:  u = mk(OP_SUB, T1, T1, S_MO);
      7'd3:  u = mk(OP_MUL, T2, S_RHO, S_AT);
      7'd4:  u = mk(OP_SUB, T2, T2, S_MT);
      7'd5:  u = mk(OP_DIV, T3, T1, S_RHO);
      7'd6:  u = mk(OP_DIV, T4, T2, S_RHO);
      7'd7:  u = mk(OP_MUL, T5, S_K0, S_K0);
      7'd8:  u = mk(OP_MUL, T6, S_K1, S_K1);
      7'd9:  u = mk(OP_ADD, T5, T5, T6);
      7'd10: u = mk(OP_SUB, T7, S_O, S_L);
      7'd11: u = mk(OP_INIT, T0, T0, T0);
      7'd12: u = mk(OP_ADD, T8, T3, S_ZERO);
      7'd13: u = mk(OP_ADD, T9, T4, S_ZERO);
      7'd14: u = mk(OP_CALL, T0, T0, T0);
      7'd15: u = mk(OP_ADD, T8, S_ZERO, S_ZERO);
      7'd16: u = mk(OP_ADD, T9, T4, S_ZERO);
      7'd17: u = mk(OP_CALL, T0, T0, T0);
      7'd18: u = mk(OP_ADD, T8, S_HUND, S_ZERO);
      7'd19: u = mk(OP_ADD, T9, T4, S_ZERO);
      7'd20: u = mk(OP_CALL, T0, T0, T0);
      7'd21: u = mk(OP_MUL, T10, S_K0, T1);
      7'd22: u = mk(OP_MUL, T11, S_K1, T2);
      7'd23: u = mk(OP_ADD, T10, T10, T11);
      7'd24: u = mk(OP_DIV, T10, T10, S_RHO);
      7'd25: u = mk(OP_ADD, T10, T7, T10);
      7'd26: u = mk(OP_MUL, T11, S_K0, T10);
      7'd27: u = mk(OP_DIV, T11, T11, T5);
      7'd28: u = mk(OP_SUB, T8, T3, T11);
      7'd29: u = mk(OP_MUL, T11, S_K1, T10);
      7'd30: u = mk(OP_DIV, T11, T11, T5);
      7'd31: u = mk(OP_SUB, T9, T4, T11);
      7'd32: u = mk(OP_CALL, T0, T0, T0);
      7'd33: u = mk(OP_MUL, T10, T6, T2);
      7'd34: u = mk(OP_DIV, T10, T10, S_RHO);
      7'd35: u = mk(OP_MUL, T11, S_K1, T7);
      7'd36: u = mk(OP_ADD, T12, T11, T10);
      7'd37: u = mk(OP_DIV, T12, T12, T6);
      7'd38: u = mk(OP_SUB, T9, T4, T12);
      7'd39: u = mk(OP_ADD, T8, S_ZERO, S_ZERO);
      7'd40: u = mk(OP_CALL, T0, T0, T0);
      7'd41: u = mk(OP_MUL, T12, S_HUND, S_K1);
      7'd42: u = mk(OP_MUL, T12, T12, S_K0);
      7'd43: u = mk(OP_ADD, T12, T11, T12);
      7'd44: u = mk(OP_ADD, T12, T12, T10);
      7'd45: u = mk(OP_DIV, T12, T12, T6);
      7'd46: u = mk(OP_SUB, T9, T4, T12);
      7'd47: u = mk(OP_ADD, T8, S_HUND, S_ZERO);
      7'd48: u = mk(OP_CALL, T0, T0, T0);
      7'd49: u = mk(OP_EMIT, T0, T0, T0);
      7'd50: u = mk(OP_MUL, T0, S_K0, T8);
      7'd51: u = mk(OP_MUL, T12, S_K1, T9);
      7'd52: u = mk(OP_ADD, T0, T0, T12);
      7'd53: u = mk(OP_SUB, T12, S_L, S_O);
      7'd54: u = mk(OP_SUB, T12, T12, S_TOL);
      7'd55: u = mk(OP_FEAS, T0, T0, T12);
      7'd56: u = mk(OP_FEAS, T0, T8, S_NTOL);
      7'd57: u = mk(OP_FEAS, T0, S_HTOL, T8);
      7'd58: u = mk(OP_SUB, T13, T8, S_AO);
      7'd59: u = mk(OP_SUB, T14, T9, S_AT);
      7'd60: u = mk(OP_MUL, T0, S_C, T8);
      7'd61: u = mk(OP_MUL, T12, S_MO, T13);
      7'd62: u = mk(OP_ADD, T0, T0, T12);
      7'd63: u = mk(OP_MUL, T12, S_MT, T14);
      7'd64: u = mk(OP_ADD, T0, T0, T12);
      7'd65: u = mk(OP_MUL, T12, T13, T13);
      7'd66: u = mk(OP_MUL, T15, T14, T14);
      7'd67: u = mk(OP_ADD, T12, T12, T15);
      7'd68: u = mk(OP_MUL, T12, S_RHOH, T12);
      7'd69: u = mk(OP_ADD, T0, T0, T12);
      7'd70: u = mk(OP_KEEP, T0, T8, T9);
      7'd71: u = mk(OP_RET, T0, T0, T0);
      7'd72: u = mk(OP_AVG, S_AO, S_BO, S_PS);
      7'd73: u = mk(OP_AVG, S_AT, S_BT, S_PP);
      7'd74: u = mk(OP_SUB, T0, S_BO, S_AO);
      7'd75: u = mk(OP_MUL, T0, S_RHO, T0);
      7'd76: u = mk(OP_ADD, S_MO, S_MO, T0);
      7'd77: u = mk(OP_SUB, T0, S_BT, S_AT);
      7'd78: u = mk(OP_MUL, T0, S_RHO, T0);
      7'd79: u = mk(OP_ADD, S_MT, S_MT, T0);
      default: u = mk(OP_DONE, T0, T0, T0);
    endcase
    return u;
  endfunction

endpackage

>>> hw/rtl/admm_if.sv
// Valid/ready channel interfaces for the ADMM dimming solver.
// Depends on nothing; used by the top level.
interface admm_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] peer_for_self;
  logic signed [31:0] peer_for_peer;
  modport source (output valid, output cmd, output peer_for_self, output peer_for_peer,
                  input ready);
  modport sink (input valid, input cmd, input peer_for_self, input peer_for_peer,
                output ready);
endinterface

interface admm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] send_for_peer;
  logic signed [31:0] send_for_self;
  logic               found;
  modport source (output valid, output send_for_peer, output send_for_self, output found,
                  input ready);
  modport sink (input valid, input send_for_peer, input send_for_self, input found,
                output ready);
endinterface

>>> hw/rtl/admm_ctrl.sv
// Controller of the ADMM dimming solver: sequences the micro-program ROM.
// Depends on admm_pkg.
module admm_ctrl
  import admm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  dp_cmd,
  input  dp_stat_t dp_stat
);

  ctrl_state_t      state_r, state_nxt;
  logic [PC_W-1:0]  pc_r, pc_nxt;
  logic [PC_W-1:0]  ret_r, ret_nxt;
  uins_t            ins;

  assign ins = rom(pc_r);

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r;
    ret_nxt = ret_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pc_nxt = in_cmd ? PC_CONS : PC_PRIMAL;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (ins.op)
          OP_CALL: begin
            ret_nxt = pc_r + 1'b1;
            pc_nxt = PC_BODY;
            state_nxt = ST_FETCH;
          end
          OP_RET: begin
            pc_nxt = ret_r;
            state_nxt = ST_FETCH;
          end
          OP_EMIT: state_nxt = ST_OUT;
          OP_DONE: state_nxt = ST_IDLE;
          default: state_nxt = ST_WAIT;
        endcase
      end
      ST_WAIT: begin
        if (dp_stat.done) begin
          pc_nxt = pc_r + 1'b1;
          state_nxt = ST_FETCH;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_valid = 1'b0;
    dp_cmd.load_in = 1'b0;
    dp_cmd.fetch = 1'b0;
    dp_cmd.start = 1'b0;
    dp_cmd.ins = ins;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        dp_cmd.load_in = in_valid;
      end
      ST_FETCH: dp_cmd.fetch = 1'b1;
      ST_EXEC: begin
        case (ins.op)
          OP_CALL, OP_RET, OP_EMIT, OP_DONE: dp_cmd.start = 1'b0;
          default: dp_cmd.start = 1'b1;
        endcase
      end
      ST_OUT: out_valid = 1'b1;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= PC_PRIMAL;
      ret_r <= PC_PRIMAL;
    end else begin
      state_r <= state_nxt;
      pc_r <= pc_nxt;
      ret_r <= ret_nxt;
    end
  end

endmodule

>>> hw/rtl/admm_dp.sv
// Datapath of the ADMM dimming solver: scratch memory, saturating adder,
// registered multiplier, bit-serial divider, candidate selection and state.
// Depends on admm_pkg.
module admm_dp
  import admm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  dp_cmd,
  output dp_stat_t                 dp_stat,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_idx,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic signed [WORD_W-1:0] in_ps,
  input  logic signed [WORD_W-1:0] in_pp,
  output logic signed [WORD_W-1:0] out_send_for_peer,
  output logic signed [WORD_W-1:0] out_send_for_self,
  output logic                     out_found
);

  logic [CFG_W-1:0] c_r, l_r, o_r, k0_r, k1_r, rho_r;
  logic signed [WORD_W-1:0] ao_r, at_r, mo_r, mt_r, bo_r, bt_r;
  logic signed [WORD_W-1:0] ps_r, pp_r, last_r, bcost_r;
  logic have_r, infeas_r, done_r;
  logic signed [WORD_W-1:0] tmp_mem_r [16];
  logic signed [WORD_W-1:0] rda_r, rdb_r;

  logic signed [2*WORD_W-1:0] prod_r;
  logic mul_busy_r;

  logic div_busy_r, div_fin_r, div_neg_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [DIV_STEPS-1:0] div_n_r, div_q_r;
  logic [WORD_W-1:0] div_d_r, div_rem_r;

  uins_t ins;
  logic signed [WORD_W-1:0] opa, opb, wr_val;
  logic wr_en;
  logic [WORD_W:0] div_t;
  logic div_ge;
  logic [WORD_W-1:0] mag_a, mag_b;
  logic signed [WORD_W:0] avg_sum, avg_adj;
  logic keep;

  assign ins = dp_cmd.ins;

  function automatic logic signed [WORD_W-1:0] sat33(input logic signed [WORD_W:0] s);
    if (s[WORD_W] != s[WORD_W-1]) begin
      return s[WORD_W] ? S32_MIN : S32_MAX;
    end
    return s[WORD_W-1:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] qmul_fin(input logic signed [2*WORD_W-1:0] p);
    logic signed [47:0] q;
    q = p[63:16];
    if (p[63] && (p[15:0] != 16'd0)) begin
      q = q + 48'sd1;
    end
    if (q[47:31] != {17{q[47]}}) begin
      return q[47] ? S32_MIN : S32_MAX;
    end
    return q[31:0];
  endfunction

  function automatic logic signed [WORD_W-1:0] sel_val(input sel_t s,
                                                        input logic signed [WORD_W-1:0] m);
    logic signed [WORD_W-1:0] v;
    case (s)
      S_C:     v = {1'b0, c_r};
      S_L:     v = {1'b0, l_r};
      S_O:     v = {1'b0, o_r};
      S_K0:    v = {1'b0, k0_r};
      S_K1:    v = {1'b0, k1_r};
      S_RHO:   v = {1'b0, rho_r};
      S_AO:    v = ao_r;
      S_AT:    v = at_r;
      S_MO:    v = mo_r;
      S_MT:    v = mt_r;
      S_ZERO:  v = '0;
      S_HUND:  v = HUNDRED_Q;
      S_NTOL:  v = -TOL_Q;
      S_HTOL:  v = HUNDRED_Q + TOL_Q;
      S_TOL:   v = TOL_Q;
      S_RHOH:  v = {2'b00, rho_r[CFG_W-1:1]};
      S_BO:    v = bo_r;
      S_BT:    v = bt_r;
      S_PS:    v = ps_r;
      S_PP:    v = pp_r;
      default: v = m;
    endcase
    return v;
  endfunction

  always_comb begin
    opa = sel_val(ins.a, rda_r);
    opb = sel_val(ins.b, rdb_r);
    mag_a = opa[WORD_W-1] ? WORD_W'(-opa) : WORD_W'(opa);
    mag_b = opb[WORD_W-1] ? WORD_W'(-opb) : WORD_W'(opb);
    avg_sum = {opa[WORD_W-1], opa} + {opb[WORD_W-1], opb};
    avg_adj = avg_sum + {{WORD_W{1'b0}}, avg_sum[WORD_W] & avg_sum[0]};
    div_t = {div_rem_r, div_n_r[DIV_STEPS-1]};
    div_ge = div_t >= {1'b0, div_d_r};
    keep = !infeas_r && (!have_r || (last_r < bcost_r));
  end

  // One result write per cycle at most: combinational ops, multiply finish
  // or divide finish never overlap because the controller issues one op.
  always_comb begin
    wr_en = 1'b0;
    wr_val = '0;
    if (dp_cmd.start) begin
      case (ins.op)
        OP_ADD: begin
          wr_en = 1'b1;
          wr_val = sat33({opa[WORD_W-1], opa} + {opb[WORD_W-1], opb});
        end
        OP_SUB: begin
          wr_en = 1'b1;
          wr_val = sat33({opa[WORD_W-1], opa} - {opb[WORD_W-1], opb});
        end
        OP_AVG: begin
          wr_en = 1'b1;
          wr_val = avg_adj[WORD_W:1];
        end
        OP_DIV: begin
          if (opb == '0) begin
            wr_en = 1'b1;
            wr_val = (opa > 0) ? S32_MAX : ((opa < 0) ? S32_MIN : '0);
          end
        end
        default: wr_en = 1'b0;
      endcase
    end
    if (mul_busy_r) begin
      wr_en = 1'b1;
      wr_val = qmul_fin(prod_r);
    end
    if (div_fin_r) begin
      wr_en = 1'b1;
      if (!div_neg_r) begin
        wr_val = (div_q_r > DIV_STEPS'(S32_MAX)) ? S32_MAX : div_q_r[WORD_W-1:0];
      end else begin
        wr_val = (div_q_r > DIV_STEPS'(33'h0_8000_0000)) ? S32_MIN
                 : WORD_W'(-div_q_r[WORD_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (ins.dst < S_C)) begin
      tmp_mem_r[ins.dst[3:0]] <= wr_val;
    end
    if (dp_cmd.fetch) begin
      rda_r <= tmp_mem_r[ins.a[3:0]];
      rdb_r <= tmp_mem_r[ins.b[3:0]];
    end
    if (dp_cmd.load_in) begin
      ps_r <= in_ps;
      pp_r <= in_pp;
    end
    if (wr_en) begin
      last_r <= wr_val;
    end
    if (dp_cmd.start && (ins.op == OP_MUL)) begin
      prod_r <= opa * opb;
    end
    if (dp_cmd.start && (ins.op == OP_DIV)) begin
      div_n_r <= {mag_a, 16'd0};
      div_d_r <= mag_b;
      div_rem_r <= '0;
      div_q_r <= '0;
      div_cnt_r <= '0;
      div_neg_r <= opa[WORD_W-1] ^ opb[WORD_W-1];
    end else if (div_busy_r) begin
      div_rem_r <= div_ge ? div_t[WORD_W-1:0] - div_d_r : div_t[WORD_W-1:0];
      div_q_r <= {div_q_r[DIV_STEPS-2:0], div_ge};
      div_n_r <= {div_n_r[DIV_STEPS-2:0], 1'b0};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (dp_cmd.start && (ins.op == OP_KEEP) && keep) begin
      bcost_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r <= CFG_W'(Q_ONE);
      l_r <= '0;
      o_r <= '0;
      k0_r <= CFG_W'(Q_ONE);
      k1_r <= CFG_W'(Q_ONE);
      rho_r <= CFG_W'(Q_ONE);
      ao_r <= '0;
      at_r <= '0;
      mo_r <= '0;
      mt_r <= '0;
      bo_r <= -Q_ONE;
      bt_r <= -Q_ONE;
      have_r <= 1'b0;
      infeas_r <= 1'b0;
      done_r <= 1'b0;
      mul_busy_r <= 1'b0;
      div_busy_r <= 1'b0;
      div_fin_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ENERGY_COST:    c_r <= cfg_data;
          CFG_LUX_TARGET:     l_r <= cfg_data;
          CFG_BACKGROUND_LUX: o_r <= cfg_data;
          CFG_GAIN_OWN:       k0_r <= cfg_data;
          CFG_GAIN_OTHER:     k1_r <= cfg_data;
          CFG_PENALTY_RHO:    rho_r <= cfg_data;
          default:            c_r <= c_r;
        endcase
      end
      if (wr_en) begin
        case (ins.dst)
          S_AO:    ao_r <= wr_val;
          S_AT:    at_r <= wr_val;
          S_MO:    mo_r <= wr_val;
          S_MT:    mt_r <= wr_val;
          default: ao_r <= ao_r;
        endcase
      end
      done_r <= 1'b0;
      mul_busy_r <= 1'b0;
      div_fin_r <= 1'b0;
      if (dp_cmd.start) begin
        case (ins.op)
          OP_MUL: mul_busy_r <= 1'b1;
          OP_DIV: begin
            if (opb == '0) begin
              done_r <= 1'b1;
            end else begin
              div_busy_r <= 1'b1;
            end
          end
          OP_FEAS: begin
            infeas_r <= infeas_r | (opa < opb);
            done_r <= 1'b1;
          end
          OP_KEEP: begin
            if (keep) begin
              have_r <= 1'b1;
              bo_r <= opa;
              bt_r <= opb;
            end
            infeas_r <= 1'b0;
            done_r <= 1'b1;
          end
          OP_INIT: begin
            have_r <= 1'b0;
            infeas_r <= 1'b0;
            bo_r <= -Q_ONE;
            bt_r <= -Q_ONE;
            done_r <= 1'b1;
          end
          default: done_r <= 1'b1;
        endcase
      end
      if (mul_busy_r) begin
        done_r <= 1'b1;
      end
      if (div_busy_r && (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1))) begin
        div_busy_r <= 1'b0;
        div_fin_r <= 1'b1;
      end
      if (div_fin_r) begin
        done_r <= 1'b1;
      end
    end
  end

  assign dp_stat.done = done_r;
  assign out_send_for_peer = bt_r;
  assign out_send_for_self = bo_r;
  assign out_found = have_r;

endmodule

>>> hw/rtl/admm_two_node_dimming_solver_unit.sv
// Top level of one node of the two-node ADMM consensus dimming solver.
// Depends on admm_pkg, admm_if, admm_ctrl and admm_dp.

// The block takes one transaction at a time. A primal transaction (cmd 0)
// tries six closed-form duty candidates in signed Q16.16, keeps the feasible
// one of lowest augmented-Lagrangian cost and returns one result transaction
// with the pair swapped for the peer and a found flag. A consensus
// transaction (cmd 1) averages the stored best pair with the peer's proposal,
// updates the multipliers and returns nothing. A micro-programmed sequencer
// issues one operation at a time to a shared datapath with a registered
// 32x32 multiplier and a divider that produces one quotient bit per cycle
// over 48 bits; the eight divisions of a primal step use that divider, but
// a zero divisor saturates the result without it. New input is accepted
// only when the previous transaction has finished and its result, if any,
// was taken.
// Configuration writes must be made while the block is idle.
module admm_two_node_dimming_solver_unit
  import admm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  admm_in_if.sink              in_ch,
  admm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  admm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat)
  );

  admm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_cmd            (dp_cmd),
    .dp_stat           (dp_stat),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data),
    .in_ps             (in_ch.peer_for_self),
    .in_pp             (in_ch.peer_for_peer),
    .out_send_for_peer (out_ch.send_for_peer),
    .out_send_for_self (out_ch.send_for_self),
    .out_found         (out_ch.found)
  );

  // A pending result blocks new input.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input ready while a result is pending");

  // With no feasible candidate both duties report minus one.
  a_not_found_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |->
      ((out_ch.send_for_self == -Q_ONE) && (out_ch.send_for_peer == -Q_ONE)))
    else $error("result without a feasible candidate has a stale pair");

  // An accepted transaction keeps the input closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted again right after a transaction");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the two-node ADMM dimming solver unit.
// Depends on admm_pkg and the admm_in_if / admm_out_if channel interfaces.
`timescale 1ns / 100ps

module testbench;
  import admm_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] peer_for_self;
    logic signed [31:0] peer_for_peer;
  } dimming_req_t;

  typedef struct packed {
    logic signed [31:0] send_for_peer;
    logic signed [31:0] send_for_self;
    logic               found;
  } proposal_t;

  localparam logic CMD_PRIMAL = 1'b0;
  localparam logic CMD_CONSENSUS = 1'b1;
  localparam int TAIL_IDLE = 200;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  admm_in_if in_ch ();
  admm_out_if out_ch ();

  admm_two_node_dimming_solver_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow of the configuration and the solver state.
  logic signed [31:0] sh_c, sh_l, sh_o, sh_k0, sh_k1, sh_rho;
  logic signed [31:0] sh_avg_own, sh_avg_other, sh_mult_own, sh_mult_other;
  logic signed [31:0] sh_best_own, sh_best_other;
  logic signed [31:0] run_cost;
  logic run_have;

  dimming_req_t pending_reqs[$];
  proposal_t expected_proposals[$];
  int errors = 0;
  bit quiet_mode = 0;
  longint cycles = 0;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  // Exact 64-bit product scaled back by 2^16, truncating toward zero.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
    return clamp32((longint'(a) * longint'(b)) / 65536);
  endfunction

  // A zero divisor saturates to the sign of the dividend.
  function automatic logic signed [31:0] fx_div(input logic signed [31:0] a, b);
    if (b == 0) begin
      if (a > 0) return 32'sh7FFF_FFFF;
      if (a < 0) return 32'sh8000_0000;
      return 0;
    end
    return clamp32((longint'(a) * 65536) / longint'(b));
  endfunction

  function automatic void try_duty_pair(input logic signed [31:0] d1, d2);
    logic signed [31:0] lux, need, e1, e2, lin, quad, cst;
    lux = fx_add(fx_mul(sh_k0, d1), fx_mul(sh_k1, d2));
    need = fx_sub(fx_sub(sh_l, sh_o), TOL_Q);
    if (d1 < -TOL_Q || lux < need || d1 > HUNDRED_Q + TOL_Q) return;
    e1 = fx_sub(d1, sh_avg_own);
    e2 = fx_sub(d2, sh_avg_other);
    lin = fx_add(fx_add(fx_mul(sh_c, d1), fx_mul(sh_mult_own, e1)),
                 fx_mul(sh_mult_other, e2));
    quad = fx_mul(sh_rho / 2, fx_add(fx_mul(e1, e1), fx_mul(e2, e2)));
    cst = fx_add(lin, quad);
    // Strictly lower cost wins, so the first of equal costs is kept.
    if (!run_have || cst < run_cost) begin
      run_have = 1;
      run_cost = cst;
      sh_best_own = d1;
      sh_best_other = d2;
    end
  endfunction

  // Advances the shadow state by one accepted request and queues any result.
  function automatic void solve_request(input dimming_req_t r);
    logic signed [31:0] z1, z2, u1, u2, m, n, ol, t, nz, k1ol, hk;
    proposal_t p;
    if (r.cmd == CMD_CONSENSUS) begin
      sh_avg_own = 32'((longint'(sh_best_own) + longint'(r.peer_for_self)) / 2);
      sh_avg_other = 32'((longint'(sh_best_other) + longint'(r.peer_for_peer)) / 2);
      sh_mult_own = fx_add(sh_mult_own, fx_mul(sh_rho, fx_sub(sh_best_own, sh_avg_own)));
      sh_mult_other = fx_add(sh_mult_other,
                             fx_mul(sh_rho, fx_sub(sh_best_other, sh_avg_other)));
      return;
    end
    z1 = fx_sub(fx_sub(fx_mul(sh_rho, sh_avg_own), sh_c), sh_mult_own);
    z2 = fx_sub(fx_mul(sh_rho, sh_avg_other), sh_mult_other);
    u1 = fx_div(z1, sh_rho);
    u2 = fx_div(z2, sh_rho);
    m = fx_add(fx_mul(sh_k0, sh_k0), fx_mul(sh_k1, sh_k1));
    n = fx_mul(sh_k1, sh_k1);
    ol = fx_sub(sh_o, sh_l);
    run_have = 0;
    run_cost = 0;
    sh_best_own = -Q_ONE;
    sh_best_other = -Q_ONE;
    try_duty_pair(u1, u2);
    try_duty_pair(0, u2);
    try_duty_pair(HUNDRED_Q, u2);
    t = fx_add(ol, fx_div(fx_add(fx_mul(sh_k0, z1), fx_mul(sh_k1, z2)), sh_rho));
    try_duty_pair(fx_sub(u1, fx_div(fx_mul(sh_k0, t), m)),
                  fx_sub(u2, fx_div(fx_mul(sh_k1, t), m)));
    nz = fx_div(fx_mul(n, z2), sh_rho);
    k1ol = fx_mul(sh_k1, ol);
    try_duty_pair(0, fx_sub(u2, fx_div(fx_add(k1ol, nz), n)));
    hk = fx_mul(fx_mul(HUNDRED_Q, sh_k1), sh_k0);
    try_duty_pair(HUNDRED_Q, fx_sub(u2, fx_div(fx_add(fx_add(k1ol, hk), nz), n)));
    p.send_for_peer = sh_best_other;
    p.send_for_self = sh_best_own;
    p.found = run_have;
    expected_proposals.push_back(p);
  endfunction

  // Driver: presents queued requests with random idle bursts.
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= CMD_PRIMAL;
      in_ch.peer_for_self <= '0;
      in_ch.peer_for_peer <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        solve_request(pending_reqs.pop_front());
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !(in_ch.valid && in_ch.ready)) begin
          in_ch.valid <= 1'b1;
          in_ch.cmd <= pending_reqs[0].cmd;
          in_ch.peer_for_self <= pending_reqs[0].peer_for_self;
          in_ch.peer_for_peer <= pending_reqs[0].peer_for_peer;
        end else begin
          in_ch.valid <= 1'b0;
          if (!quiet_mode && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 15);
        end
      end
    end
  end

  // Monitor: takes results with random stalls and checks them in order.
  int recv_stall = 0;
  always @(posedge clk) begin
    proposal_t exp_p;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_proposals.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          exp_p = expected_proposals.pop_front();
          if (out_ch.send_for_peer !== exp_p.send_for_peer) begin
            $error("send_for_peer expected %0d got %0d", exp_p.send_for_peer,
                   out_ch.send_for_peer);
            errors++;
          end
          if (out_ch.send_for_self !== exp_p.send_for_self) begin
            $error("send_for_self expected %0d got %0d", exp_p.send_for_self,
                   out_ch.send_for_self);
            errors++;
          end
          if (out_ch.found !== exp_p.found) begin
            $error("found expected %0d got %0d", exp_p.found, out_ch.found);
            errors++;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        recv_stall <= $urandom_range(1, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Generous cycle limit on the whole run.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_duty();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 6553600);
      1: return $signed($urandom_range(0, 13107200)) - 32'sd3276800;
      2: return $urandom();
      default: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    endcase
  endfunction

  task automatic queue_req(input logic cmd, input logic signed [31:0] ps, pp);
    dimming_req_t r;
    r.cmd = cmd;
    r.peer_for_self = ps;
    r.peer_for_peer = pp;
    pending_reqs.push_back(r);
  endtask

  // Waits until every request is taken and every result has arrived, then
  // lets a consensus step finish before the configuration may change.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_ch.valid || expected_proposals.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // The enable is held for one edge and dropped for the next, so that
  // back-to-back writes never schedule two updates in one time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_ENERGY_COST: sh_c = {1'b0, val};
      CFG_LUX_TARGET: sh_l = {1'b0, val};
      CFG_BACKGROUND_LUX: sh_o = {1'b0, val};
      CFG_GAIN_OWN: sh_k0 = {1'b0, val};
      CFG_GAIN_OTHER: sh_k1 = {1'b0, val};
      CFG_PENALTY_RHO: sh_rho = {1'b0, val};
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CFG_W-1:0] c, l, o, k0, k1, rho);
    write_reg(CFG_ENERGY_COST, c);
    write_reg(CFG_LUX_TARGET, l);
    write_reg(CFG_BACKGROUND_LUX, o);
    write_reg(CFG_GAIN_OWN, k0);
    write_reg(CFG_GAIN_OTHER, k1);
    write_reg(CFG_PENALTY_RHO, rho);
  endtask

  // A well-formed iteration is a primal step then the peer's consensus reply.
  task automatic queue_iterations(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_req(1'($urandom_range(0, 1)), rand_duty(), rand_duty());
      end else begin
        queue_req(CMD_PRIMAL, rand_duty(), rand_duty());
        queue_req(CMD_CONSENSUS, rand_duty(), rand_duty());
      end
    end
  endtask

  initial begin
    sh_c = Q_ONE; sh_l = 0; sh_o = 0; sh_k0 = Q_ONE; sh_k1 = Q_ONE; sh_rho = Q_ONE;
    sh_avg_own = 0; sh_avg_other = 0; sh_mult_own = 0; sh_mult_other = 0;
    sh_best_own = -Q_ONE; sh_best_other = -Q_ONE;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: consensus before any primal step, then field extremes.
    queue_req(CMD_CONSENSUS, 32'sd0, 32'sd0);
    queue_req(CMD_PRIMAL, 32'sd0, 32'sd0);
    queue_req(CMD_CONSENSUS, 32'sh7FFF_FFFF, 32'sh8000_0000);
    queue_req(CMD_PRIMAL, 32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_req(CMD_CONSENSUS, 32'sh8000_0000, 32'sh7FFF_FFFF);
    queue_req(CMD_PRIMAL, 32'sd0, 32'sd0);
    queue_req(CMD_CONSENSUS, HUNDRED_Q, -1);
    queue_req(CMD_PRIMAL, 32'sd0, 32'sd0);
    drain();

    // Unreachable illuminance: no candidate is feasible.
    write_all(31'd65536, 31'h7FFF_FFFF, 31'd0, 31'd0, 31'd1, 31'd65536);
    queue_req(CMD_PRIMAL, 32'sd0, 32'sd0);
    queue_req(CMD_CONSENSUS, 32'sd12345, -32'sd777);
    queue_req(CMD_PRIMAL, 32'sd0, 32'sd0);
    drain();

    // Register extremes: tiny rho and other gain so n collapses to zero.
    write_all(31'd0, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 31'd1);
    queue_iterations(4);
    drain();
    write_all(31'h7FFF_FFFF, 31'd3276800, 31'd65536, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_iterations(4);
    drain();

    // Random phases; each ends in a drain so that new registers can be set.
    for (int ph = 0; ph < 16; ph++) begin
      write_all(CFG_W'($urandom_range(0, 262144)), CFG_W'($urandom_range(0, 13107200)),
                CFG_W'($urandom_range(0, 3276800)), CFG_W'($urandom_range(0, 131072)),
                CFG_W'($urandom_range(1, 131072)), CFG_W'($urandom_range(1, 262144)));
      if (ph % 4 == 3)
        write_reg(CFG_IDX_W'($urandom_range(0, 5)), CFG_W'($urandom()));
      queue_iterations(10);
      if (ph == 8) begin
        // Hold the sender until all outstanding results have come back.
        drain();
        queue_iterations(3);
      end
      if (ph == 13) quiet_mode = 1;
      drain();
    end

    repeat (TAIL_IDLE) @(posedge clk);
    if (expected_proposals.size() != 0) begin
      $error("results still outstanding: %0d", expected_proposals.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
